### rtl/core/rbff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbff_pkg
// Shared types and constants for the receive ring buffer with flow flags.
// ----------------------------------------------------------------------------
package rbff_pkg;

    // ring depth, a power of two; one slot always stays empty
    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LERR_W   = 2;
    localparam int ERR_W    = 3;
    localparam int FILL_W   = 8;
    localparam int THRESH_W = 8;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd128;
    localparam logic [ERR_W-1:0]    OVERFLOW_CODE   = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_COUNT     = 3'd2,
        CMD_WR_DRAIN  = 3'd3,
        CMD_WR_OVF    = 3'd4
    } rbff_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } rbff_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] rx_byte;
        logic [LERR_W-1:0] line_error;
        logic              flag_value;
    } rbff_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [ERR_W-1:0]  error_code;
        logic              no_data;
        logic [FILL_W-1:0] fill_count;
        logic              drain_flag;
        logic              overflow_flag;
    } rbff_out_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // execute the word on the input now
        logic load_data;  // capture memory read data into the result
    } rbff_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;    // input word is a pop on a non-empty ring
    } rbff_status_t;

endpackage

### rtl/core/rbff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rbff_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbff_ctrl
// Sequencer: takes one word, waits on the memory read for a pop, then
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module rbff_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  rbff_pkg::rbff_status_t status,
    output rbff_pkg::rbff_ctrl_t   ctrl
);

    rbff_pkg::rbff_state_t state_reg;
    rbff_pkg::rbff_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbff_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbff_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.pop_hit ? rbff_pkg::ST_READ : rbff_pkg::ST_OUT;
                end
            end
            rbff_pkg::ST_READ:
            begin
                state_next = rbff_pkg::ST_OUT;
            end
            rbff_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = rbff_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbff_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        ctrl.take      = 1'b0;
        ctrl.load_data = 1'b0;
        case (state_reg)
            rbff_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.take = in_valid;
            end
            rbff_pkg::ST_READ:
            begin
                ctrl.load_data = 1'b1;
            end
            rbff_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/rbff_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbff_datapath
// Ring pointers, flags, latched error, threshold register, byte store and
// the result register.
// ----------------------------------------------------------------------------
module rbff_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbff_pkg::rbff_in_t             in_word,
    input  logic                           cfg_we,
    input  logic [rbff_pkg::THRESH_W-1:0]  cfg_data,
    input  rbff_pkg::rbff_ctrl_t           ctrl,
    output rbff_pkg::rbff_status_t         status,
    output rbff_pkg::rbff_out_t            out_word
);

    logic [rbff_pkg::PTR_W-1:0]    wr_reg, wr_next;
    logic [rbff_pkg::PTR_W-1:0]    rd_reg, rd_next;
    logic [rbff_pkg::ERR_W-1:0]    last_err_reg, last_err_next;
    logic                          drain_reg, drain_next;
    logic                          ovf_reg, ovf_next;
    logic [rbff_pkg::THRESH_W-1:0] thresh_reg;
    rbff_pkg::rbff_out_t           res_reg, res_next;

    logic [rbff_pkg::PTR_W-1:0]    wr_inc;
    logic [rbff_pkg::PTR_W-1:0]    rd_inc;
    logic                          empty;
    logic                          ram_we;
    logic                          ram_re;
    logic [rbff_pkg::BYTE_W-1:0]   ram_rdata;

    assign wr_inc = wr_reg + 1'b1;
    assign rd_inc = rd_reg + 1'b1;
    assign empty  = (wr_reg == rd_reg);

    assign status.pop_hit = (in_word.command == rbff_pkg::CMD_POP) && !empty;

    always_comb
    begin
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        last_err_next = last_err_reg;
        drain_next    = drain_reg;
        ovf_next      = ovf_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        res_next      = res_reg;

        if (ctrl.take)
        begin
            res_next = '0;
            case (in_word.command)
                rbff_pkg::CMD_PUSH:
                begin
                    // threshold test runs even when the push is dropped
                    if (wr_inc + rbff_pkg::PTR_W'(thresh_reg) == rd_reg)
                    begin
                        drain_next = 1'b0;
                    end
                    if (wr_inc == rd_reg)
                    begin
                        last_err_next = rbff_pkg::OVERFLOW_CODE;
                        ovf_next      = 1'b1;
                    end
                    else
                    begin
                        last_err_next = rbff_pkg::ERR_W'(in_word.line_error);
                        wr_next       = wr_inc;
                        ram_we        = 1'b1;
                    end
                    res_next.error_code = last_err_next;
                end
                rbff_pkg::CMD_POP:
                begin
                    if (empty)
                    begin
                        res_next.no_data = 1'b1;
                    end
                    else
                    begin
                        rd_next = rd_inc;
                        ram_re  = 1'b1;
                        if (rd_inc + 1'b1 == wr_reg)
                        begin
                            drain_next = 1'b1;
                        end
                        res_next.error_code = last_err_reg;
                    end
                end
                rbff_pkg::CMD_WR_DRAIN:
                begin
                    drain_next = in_word.flag_value;
                end
                rbff_pkg::CMD_WR_OVF:
                begin
                    ovf_next = in_word.flag_value;
                end
                default:
                begin
                    res_next.no_data = 1'b0;
                end
            endcase
            res_next.fill_count    = rbff_pkg::FILL_W'(wr_next - rd_next);
            res_next.drain_flag    = drain_next;
            res_next.overflow_flag = ovf_next;
        end
        else if (ctrl.load_data)
        begin
            res_next.data_byte = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg       <= '0;
            rd_reg       <= '0;
            last_err_reg <= '0;
            drain_reg    <= 1'b1;
            ovf_reg      <= 1'b0;
            thresh_reg   <= rbff_pkg::THRESHOLD_RESET;
        end
        else
        begin
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            last_err_reg <= last_err_next;
            drain_reg    <= drain_next;
            ovf_reg      <= ovf_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    rbff_ram #(
        .WIDTH (rbff_pkg::BYTE_W),
        .DEPTH (rbff_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_inc),
        .wdata (in_word.rx_byte),
        .re    (ram_re),
        .raddr (rd_inc),
        .rdata (ram_rdata)
    );

    assign out_word = res_reg;

endmodule

### rtl/core/rx_ring_buffer_flow_flags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_buffer_flow_flags_unit
// Receive ring buffer keeping one slot empty, with drain and sticky
// overflow flags and a programmable low-space threshold.
// ----------------------------------------------------------------------------
//  channel  signals                       moves
//  in       in_valid/in_ready/in_word     one command word
//  out      out_valid/out_ready/out_word  one result word per command
//  cfg      cfg_valid/cfg_ready/cfg_data  low-space threshold, always ready
//
//  one word at a time: a pop on a non-empty ring passes through accept,
//  the registered store read and the result; every other command passes
//  through accept and the result; the result then waits on out_ready
//  the single result register holds each result until it is taken
//  reset clears pointers, latched error and overflow flag, sets the drain
//  flag; the byte store needs no clearing pass
// ----------------------------------------------------------------------------
module rx_ring_buffer_flow_flags_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rbff_pkg::rbff_in_t            in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rbff_pkg::rbff_out_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbff_pkg::THRESH_W-1:0] cfg_data
);

    rbff_pkg::rbff_ctrl_t   ctrl;
    rbff_pkg::rbff_status_t status;

    assign cfg_ready = 1'b1;

    rbff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    rbff_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .ctrl     (ctrl),
        .status   (status),
        .out_word (out_word)
    );

    // never accepting while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken before the result");

    // an empty pop carries no byte and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.no_data |->
            out_word.data_byte == '0 && out_word.error_code == '0)
        else $error("empty pop with data or error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.error_code <= rbff_pkg::OVERFLOW_CODE)
        else $error("error code out of range");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the receive ring buffer with flow flags. Command
// words go in over a valid/ready channel with random gaps and the result
// channel is stalled at random. A mirror of the ring (pointers, byte store,
// latched error, drain and overflow flags, threshold) works out every
// result, which the checker compares field by field. Covers directed
// corner cases, a fill to capacity with overflow, and random bursts under
// several threshold settings.
// ----------------------------------------------------------------------------
module testbench;

    // codes outside the command set, which the ring must ignore
    localparam logic [rbff_pkg::CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [rbff_pkg::CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    rbff_pkg::rbff_in_t            in_word;
    logic                          out_valid;
    logic                          out_ready;
    rbff_pkg::rbff_out_t           out_word;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rbff_pkg::THRESH_W-1:0] cfg_data;

    // mirror of the ring
    logic [rbff_pkg::BYTE_W-1:0]   ring_bytes [0:rbff_pkg::DEPTH-1];
    logic [rbff_pkg::PTR_W-1:0]    ring_head;
    logic [rbff_pkg::PTR_W-1:0]    ring_tail;
    logic [rbff_pkg::ERR_W-1:0]    ring_err;
    logic                          ring_drain;
    logic                          ring_ovf;
    logic [rbff_pkg::THRESH_W-1:0] ring_thresh;

    rbff_pkg::rbff_out_t replies_due[$];
    int                  words_sent;
    int                  replies_checked;
    int                  thresholds_used;
    int                  mismatches;
    bit                  quiet;

    rx_ring_buffer_flow_flags_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // advance the mirror by one command word and return the result it gives
    function automatic rbff_pkg::rbff_out_t advance_ring(rbff_pkg::rbff_in_t w);
        rbff_pkg::rbff_out_t        r;
        logic [rbff_pkg::PTR_W-1:0] nxt;
        logic [rbff_pkg::PTR_W-1:0] mark;
        logic [rbff_pkg::ERR_W-1:0] e;
        r = '0;
        case (w.command)
            rbff_pkg::CMD_PUSH:
            begin
                nxt  = ring_head + 1'b1;
                mark = nxt + rbff_pkg::PTR_W'(ring_thresh);
                e    = rbff_pkg::ERR_W'(w.line_error);
                if (mark == ring_tail)
                    ring_drain = 1'b0;
                if (nxt == ring_tail)
                begin
                    // ring full: word dropped
                    e        = rbff_pkg::OVERFLOW_CODE;
                    ring_ovf = 1'b1;
                end
                else
                begin
                    ring_head       = nxt;
                    ring_bytes[nxt] = w.rx_byte;
                end
                ring_err     = e;
                r.error_code = e;
            end
            rbff_pkg::CMD_POP:
            begin
                if (ring_head == ring_tail)
                    r.no_data = 1'b1;
                else
                begin
                    ring_tail = ring_tail + 1'b1;
                    nxt       = ring_tail + 1'b1;
                    if (nxt == ring_head)
                        ring_drain = 1'b1;
                    r.data_byte  = ring_bytes[ring_tail];
                    r.error_code = ring_err;
                end
            end
            rbff_pkg::CMD_WR_DRAIN: ring_drain = w.flag_value;
            rbff_pkg::CMD_WR_OVF:   ring_ovf = w.flag_value;
            default:                ;
        endcase
        nxt             = ring_head - ring_tail;
        r.fill_count    = rbff_pkg::FILL_W'(nxt);
        r.drain_flag    = ring_drain;
        r.overflow_flag = ring_ovf;
        return r;
    endfunction

    function automatic rbff_pkg::rbff_in_t rand_word(logic [rbff_pkg::CMD_W-1:0] cmd);
        rbff_pkg::rbff_in_t w;
        w.command    = cmd;
        w.rx_byte    = rbff_pkg::BYTE_W'($urandom);
        w.line_error = rbff_pkg::LERR_W'($urandom);
        w.flag_value = 1'($urandom);
        return w;
    endfunction

    function automatic rbff_pkg::rbff_in_t flag_word(logic [rbff_pkg::CMD_W-1:0] cmd,
                                                     logic v);
        rbff_pkg::rbff_in_t w;
        w            = rand_word(cmd);
        w.flag_value = v;
        return w;
    endfunction

    // called at a rising edge, returns at the edge where the word was taken
    task automatic send_word(rbff_pkg::rbff_in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        replies_due.push_back(advance_ring(w));
        words_sent++;
    endtask

    task automatic push_byte(logic [rbff_pkg::BYTE_W-1:0] b,
                             logic [rbff_pkg::LERR_W-1:0] le);
        rbff_pkg::rbff_in_t w;
        w            = rand_word(rbff_pkg::CMD_PUSH);
        w.rx_byte    = b;
        w.line_error = le;
        send_word(w);
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [rbff_pkg::THRESH_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ring_thresh = v;
        thresholds_used++;
    endtask

    // output side: random back-pressure, none while quiet
    initial
    begin
        int hold;
        int r;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!quiet && r < 12)
                    hold = $urandom_range(1, 3);
                else if (!quiet && r < 15)
                    hold = $urandom_range(8, 30);
            end
        end
    end

    always @(posedge clk)
    begin
        rbff_pkg::rbff_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result word with none outstanding: %h", out_word);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                replies_checked++;
                if (out_word.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h",
                           want.data_byte, out_word.data_byte);
                    mismatches++;
                end
                if (out_word.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, out_word.error_code);
                    mismatches++;
                end
                if (out_word.no_data !== want.no_data)
                begin
                    $error("no_data: expected %0b, got %0b",
                           want.no_data, out_word.no_data);
                    mismatches++;
                end
                if (out_word.fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, out_word.fill_count);
                    mismatches++;
                end
                if (out_word.drain_flag !== want.drain_flag)
                begin
                    $error("drain_flag: expected %0b, got %0b",
                           want.drain_flag, out_word.drain_flag);
                    mismatches++;
                end
                if (out_word.overflow_flag !== want.overflow_flag)
                begin
                    $error("overflow_flag: expected %0b, got %0b",
                           want.overflow_flag, out_word.overflow_flag);
                    mismatches++;
                end
            end
        end
    end

    // empty pop, every command, field extremes, flags written both ways
    task automatic test_directed();
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_COUNT));
        send_word(flag_word(rbff_pkg::CMD_WR_DRAIN, 1'b0));
        push_byte(8'h00, 2'd0);
        push_byte(8'hff, 2'd3);
        push_byte(8'ha5, 2'd1);
        push_byte(8'h5a, 2'd2);
        send_word(rand_word(rbff_pkg::CMD_COUNT));
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_POP));
        // one entry left after this pop: drain flag comes back
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(flag_word(rbff_pkg::CMD_WR_DRAIN, 1'b0));
        send_word(flag_word(rbff_pkg::CMD_WR_DRAIN, 1'b1));
        send_word(flag_word(rbff_pkg::CMD_WR_OVF, 1'b1));
        send_word(flag_word(rbff_pkg::CMD_WR_OVF, 1'b0));
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
            send_word(rand_word(rbff_pkg::CMD_W'(c)));
        send_word(rand_word(rbff_pkg::CMD_COUNT));
    endtask

    // high threshold clears drain on the first push of an empty ring
    task automatic test_threshold_high();
        write_threshold(8'd255);
        push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_POP));
        send_word(rand_word(rbff_pkg::CMD_POP));
    endtask

    // fill to capacity, overflow, then threshold zero on a full ring
    task automatic test_fill_overflow();
        write_threshold(8'd1);
        send_word(flag_word(rbff_pkg::CMD_WR_DRAIN, 1'b1));
        quiet = 1'b1;
        for (int i = 0; i < rbff_pkg::DEPTH - 1; i++)
            push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        quiet = 1'b0;
        push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        write_threshold(8'd0);
        send_word(flag_word(rbff_pkg::CMD_WR_DRAIN, 1'b1));
        push_byte(rbff_pkg::BYTE_W'($urandom), rbff_pkg::LERR_W'($urandom));
        send_word(rand_word(rbff_pkg::CMD_COUNT));
        send_word(flag_word(rbff_pkg::CMD_WR_OVF, 1'b0));
        for (int i = 0; i < 24; i++)
            send_word(rand_word(rbff_pkg::CMD_POP));
    endtask

    // bursts that lean towards push, towards pop or to neither, mixed with everything else
    task automatic test_random_bursts();
        logic [rbff_pkg::THRESH_W-1:0] settings [4];
        int                            r;
        int                            lean;
        int                            len;
        logic [rbff_pkg::CMD_W-1:0]    cmd;
        settings[0] = 8'd255;
        settings[1] = rbff_pkg::THRESH_W'($urandom_range(200, 254));
        settings[2] = rbff_pkg::THRESH_W'($urandom_range(1, 255));
        settings[3] = rbff_pkg::THRESHOLD_RESET;
        for (int s = 0; s < 4; s++)
        begin
            write_threshold(settings[s]);
            quiet = (s == 2);
            for (int n = 0; n < 25; )
            begin
                lean = $urandom_range(0, 2);
                len  = $urandom_range(4, 30);
                for (int k = 0; k < len && n < 25; k++, n++)
                begin
                    r = $urandom_range(0, 99);
                    if ((lean == 0 && r < 85) || (lean == 2 && r < 35))
                        cmd = rbff_pkg::CMD_PUSH;
                    else if ((lean == 1 && r < 85) || (lean == 2 && r < 70))
                        cmd = rbff_pkg::CMD_POP;
                    else if (r < 90)
                        cmd = rbff_pkg::CMD_COUNT;
                    else if (r < 94)
                        cmd = rbff_pkg::CMD_WR_DRAIN;
                    else if (r < 98)
                        cmd = rbff_pkg::CMD_WR_OVF;
                    else
                        cmd = rbff_pkg::CMD_W'($urandom_range(CMD_RSVD_FIRST,
                                                              CMD_RSVD_LAST));
                    send_word(rand_word(cmd));
                end
                if ($urandom_range(0, 99) < 10)
                    settle();
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        ring_head       = '0;
        ring_tail       = '0;
        ring_err        = '0;
        ring_drain      = 1'b1;
        ring_ovf        = 1'b0;
        ring_thresh     = rbff_pkg::THRESHOLD_RESET;
        words_sent      = 0;
        replies_checked = 0;
        thresholds_used = 1;
        mismatches      = 0;
        quiet           = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_high();
        test_fill_overflow();
        test_random_bursts();

        settle();
        repeat (20) @(posedge clk);
        $display("%0d command words sent, %0d results checked, %0d threshold settings",
                 words_sent, replies_checked, thresholds_used);
        $display("ring filled to capacity with overflow; random push/pop bursts");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
